[hdl/imufp_pkg.sv]
// Shared types and constants for the IMU frame parser.
// Used by the front classifier, the token queue and the back end.
`default_nettype none

package imufp_pkg;

	localparam logic [7:0] HDR_BYTE   = 8'h55;
	localparam logic [7:0] TYPE_ACC   = 8'h51;
	localparam logic [7:0] TYPE_GYRO  = 8'h52;
	localparam logic [7:0] TYPE_ANGLE = 8'h53;
	localparam logic [7:0] TYPE_QUAT  = 8'h59;

	localparam logic [1:0] KIND_ACC   = 2'd0;
	localparam logic [1:0] KIND_GYRO  = 2'd1;
	localparam logic [1:0] KIND_ANGLE = 2'd2;
	localparam logic [1:0] KIND_QUAT  = 2'd3;

	// Role of one queued byte.
	localparam logic [1:0] ROLE_START = 2'd0;
	localparam logic [1:0] ROLE_TYPE  = 2'd1;
	localparam logic [1:0] ROLE_DATA  = 2'd2;
	localparam logic [1:0] ROLE_CHECK = 2'd3;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [1:0] role;
		logic [2:0] sel;   // kind for a type byte, slot for a data byte
		logic [7:0] data;
	} token_t;

	typedef struct packed {
		logic   valid;
		token_t tok;
	} qhead_t;

endpackage

`default_nettype wire

[hdl/imufp_front.sv]
// Front end: tracks frame position and tags each frame byte with its role.
// Uses imufp_pkg; feeds imufp_queue.
`default_nettype none

module imufp_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rx_fire,
	input  wire logic [7:0]        rx_byte,
	output imufp_pkg::token_t      push_tok,
	output logic                   push
);

	localparam logic [3:0] PH_HUNT  = 4'd0;
	localparam logic [3:0] PH_TYPE  = 4'd1;
	localparam logic [3:0] PH_DATA0 = 4'd2;
	localparam logic [3:0] PH_SUM   = 4'd10;

	logic [3:0] phase_q;
	logic [3:0] phase_n;
	logic       known;
	logic [1:0] kind;
	logic [3:0] slot;

	always_comb begin
		known = 1'b1;
		kind  = imufp_pkg::KIND_ACC;
		unique case (rx_byte)
			imufp_pkg::TYPE_ACC:   kind = imufp_pkg::KIND_ACC;
			imufp_pkg::TYPE_GYRO:  kind = imufp_pkg::KIND_GYRO;
			imufp_pkg::TYPE_ANGLE: kind = imufp_pkg::KIND_ANGLE;
			imufp_pkg::TYPE_QUAT:  kind = imufp_pkg::KIND_QUAT;
			default:               known = 1'b0;
		endcase
	end

	assign slot = phase_q - PH_DATA0;

	always_comb begin
		phase_n       = phase_q;
		push          = 1'b0;
		push_tok.role = imufp_pkg::ROLE_START;
		push_tok.sel  = 3'd0;
		push_tok.data = rx_byte;
		if (rx_fire) begin
			priority if (phase_q == PH_TYPE && known) begin
				push          = 1'b1;
				push_tok.role = imufp_pkg::ROLE_TYPE;
				push_tok.sel  = {1'b0, kind};
				phase_n       = PH_DATA0;
			end else if (phase_q >= PH_DATA0 && phase_q < PH_SUM) begin
				push          = 1'b1;
				push_tok.role = imufp_pkg::ROLE_DATA;
				push_tok.sel  = slot[2:0];
				phase_n       = phase_q + 4'd1;
			end else if (phase_q == PH_SUM) begin
				push          = 1'b1;
				push_tok.role = imufp_pkg::ROLE_CHECK;
				phase_n       = PH_HUNT;
			end else if (rx_byte == imufp_pkg::HDR_BYTE) begin
				// hunting, or an unknown type byte that is itself a header
				push    = 1'b1;
				phase_n = PH_TYPE;
			end else begin
				phase_n = PH_HUNT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
		end else begin
			phase_q <= phase_n;
		end
	end

endmodule

`default_nettype wire

[hdl/imufp_queue.sv]
// Short token queue between the front classifier and the back end.
// Uses imufp_pkg for the token type and depth.
`default_nettype none

module imufp_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire imufp_pkg::token_t push_tok,
	input  wire logic              pop,
	output imufp_pkg::qhead_t      head,
	output logic                   full
);

	imufp_pkg::token_t                  mem_q [imufp_pkg::QDEPTH];
	logic [imufp_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [imufp_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [imufp_pkg::QCNT_W-1:0]      cnt_q;
	logic                              do_pop;

	localparam logic [imufp_pkg::QCNT_W-1:0] CNT_FULL =
		imufp_pkg::QCNT_W'(imufp_pkg::QDEPTH);
	localparam logic [imufp_pkg::QPTR_W-1:0] PTR_LAST =
		imufp_pkg::QPTR_W'(imufp_pkg::QDEPTH - 1);

	assign full       = (cnt_q == CNT_FULL);
	assign head.valid = (cnt_q != '0);
	assign head.tok   = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[hdl/imufp_back.sv]
// Back end: gathers payload and checksum from queued tokens, keeps per-kind
// status and holds the result register. Uses imufp_pkg.
`default_nettype none

module imufp_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire imufp_pkg::qhead_t  head,
	output logic                    pop,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic [1:0]              frame_kind,
	output logic signed [15:0]      word_a,
	output logic signed [15:0]      word_b,
	output logic signed [15:0]      word_c,
	output logic signed [15:0]      word_d,
	output logic                    sum_ok,
	output logic                    group_done,
	output logic                    group_ok
);

	logic [7:0] sum_q;
	logic [1:0] kind_q;
	logic [7:0] pay_q [8];
	logic [3:0] seen_q;
	logic [3:0] valid_q;

	logic       out_free;
	logic       is_check;
	logic       load;
	logic       ok;
	logic [3:0] bit_oh;
	logic [3:0] seen_n;
	logic [3:0] valid_n;
	logic       done;

	assign out_free = !res_valid || !res_stall;
	assign is_check = head.tok.role == imufp_pkg::ROLE_CHECK;
	// hold a checksum token until the result register can take it
	assign pop      = head.valid && (!is_check || out_free);
	assign load     = pop && is_check;

	assign ok      = head.tok.data == sum_q;
	assign bit_oh  = 4'b0001 << kind_q;
	assign seen_n  = seen_q | bit_oh;
	assign valid_n = ok ? (valid_q | bit_oh) : (valid_q & ~bit_oh);
	assign done    = seen_n == 4'hF;

	always_ff @(posedge clk) begin
		if (pop && head.tok.role == imufp_pkg::ROLE_DATA) begin
			pay_q[head.tok.sel] <= head.tok.data;
		end
		if (load) begin
			frame_kind <= kind_q;
			word_a     <= {pay_q[1], pay_q[0]};
			word_b     <= {pay_q[3], pay_q[2]};
			word_c     <= {pay_q[5], pay_q[4]};
			word_d     <= {pay_q[7], pay_q[6]};
			sum_ok     <= ok;
			group_done <= done;
			group_ok   <= done && (valid_n == 4'hF);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			kind_q    <= '0;
			seen_q    <= '0;
			valid_q   <= '0;
			res_valid <= 1'b0;
		end else begin
			if (pop) begin
				unique case (head.tok.role)
					imufp_pkg::ROLE_START: sum_q <= imufp_pkg::HDR_BYTE;
					imufp_pkg::ROLE_TYPE: begin
						sum_q  <= sum_q + head.tok.data;
						kind_q <= head.tok.sel[1:0];
					end
					imufp_pkg::ROLE_DATA:  sum_q <= sum_q + head.tok.data;
					imufp_pkg::ROLE_CHECK: begin
						sum_q   <= '0;
						seen_q  <= done ? 4'h0 : seen_n;
						valid_q <= done ? 4'h0 : valid_n;
					end
					default: sum_q <= sum_q;
				endcase
			end
			if (load) begin
				res_valid <= 1'b1;
			end else if (!res_stall) begin
				res_valid <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/imu_frame_parser.sv]
// IMU frame parser: one received byte per cycle, one result per 11-byte frame.
// The result is registered: the checksum byte passes through the token queue,
// then the result register; it waits while res_stall holds an earlier result.
// Throughput: one byte per cycle; rx_stall rises only when the 4-entry token
// queue fills, which happens only while the result port is stalled.
// Reset (arst_n low): hunting for a header, queue empty, per-kind flags clear,
// no result pending. Uses imufp_pkg, imufp_front, imufp_queue, imufp_back.
`default_nettype none

module imu_frame_parser (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               rx_valid,
	output logic                    rx_stall,
	input  wire logic [7:0]         rx_byte,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic [1:0]              frame_kind,
	output logic signed [15:0]      word_a,
	output logic signed [15:0]      word_b,
	output logic signed [15:0]      word_c,
	output logic signed [15:0]      word_d,
	output logic                    sum_ok,
	output logic                    group_done,
	output logic                    group_ok
);

	imufp_pkg::token_t  push_tok;
	imufp_pkg::qhead_t  head;
	logic               push;
	logic               pop;
	logic               full;
	logic               rx_fire;

	assign rx_stall = full;
	assign rx_fire  = rx_valid && !full;

	imufp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_fire  (rx_fire),
		.rx_byte  (rx_byte),
		.push_tok (push_tok),
		.push     (push)
	);

	imufp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_tok (push_tok),
		.pop      (pop),
		.head     (head),
		.full     (full)
	);

	imufp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.frame_kind (frame_kind),
		.word_a     (word_a),
		.word_b     (word_b),
		.word_c     (word_c),
		.word_d     (word_d),
		.sum_ok     (sum_ok),
		.group_done (group_done),
		.group_ok   (group_ok)
	);

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for imu_frame_parser: drives serial bytes, predicts
// every frame result in-line and compares it field by field on the result port.
// Depends on imufp_pkg for the header, type and kind codes.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [3:0] PH_HUNT  = 4'd0;
	localparam logic [3:0] PH_TYPE  = 4'd1;
	localparam logic [3:0] PH_DATA0 = 4'd2;
	localparam logic [3:0] PH_SUM   = 4'd10;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 150;
	localparam int SETTLE_CYCLES  = 10;
	localparam int RANDOM_BYTES   = 100;

	typedef struct {
		logic [1:0]  kind;
		logic [15:0] wa;
		logic [15:0] wb;
		logic [15:0] wc;
		logic [15:0] wd;
		logic        ok;
		logic        done;
		logic        all_ok;
	} frame_res_t;

	logic clk;
	logic arst_n;
	logic rx_valid;
	logic rx_stall;
	logic [7:0] rx_byte;
	logic res_valid;
	logic res_stall;
	logic [1:0] frame_kind;
	logic signed [15:0] word_a;
	logic signed [15:0] word_b;
	logic signed [15:0] word_c;
	logic signed [15:0] word_d;
	logic sum_ok;
	logic group_done;
	logic group_ok;

	imu_frame_parser u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx_valid),
		.rx_stall   (rx_stall),
		.rx_byte    (rx_byte),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.frame_kind (frame_kind),
		.word_a     (word_a),
		.word_b     (word_b),
		.word_c     (word_c),
		.word_d     (word_d),
		.sum_ok     (sum_ok),
		.group_done (group_done),
		.group_ok   (group_ok)
	);

	// Parser state as the testbench sees it.
	logic [3:0] parse_phase = PH_HUNT;
	logic [1:0] held_kind = imufp_pkg::KIND_ACC;
	logic [7:0] run_sum = 8'h00;
	logic [7:0] data_bytes [8];
	logic [3:0] seen_kinds = 4'h0;
	logic [3:0] good_kinds = 4'h0;

	frame_res_t frames_due[$];

	int errors = 0;
	int idle_cycles = 0;
	int bytes_sent = 0;
	int burst_left = 0;
	int gap_max = 0;
	int stall_pct = 0;
	logic hold_wanted = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Returns {known, kind} for a type byte.
	function automatic logic [2:0] kind_of_type(input logic [7:0] b);
		case (b)
			imufp_pkg::TYPE_ACC:   return {1'b1, imufp_pkg::KIND_ACC};
			imufp_pkg::TYPE_GYRO:  return {1'b1, imufp_pkg::KIND_GYRO};
			imufp_pkg::TYPE_ANGLE: return {1'b1, imufp_pkg::KIND_ANGLE};
			imufp_pkg::TYPE_QUAT:  return {1'b1, imufp_pkg::KIND_QUAT};
			default:               return 3'b000;
		endcase
	endfunction

	function automatic logic [7:0] type_of_kind(input logic [1:0] k);
		case (k)
			imufp_pkg::KIND_ACC:   return imufp_pkg::TYPE_ACC;
			imufp_pkg::KIND_GYRO:  return imufp_pkg::TYPE_GYRO;
			imufp_pkg::KIND_ANGLE: return imufp_pkg::TYPE_ANGLE;
			default:               return imufp_pkg::TYPE_QUAT;
		endcase
	endfunction

	function automatic void hunt_for_header(input logic [7:0] b);
		if (b == imufp_pkg::HDR_BYTE) begin
			parse_phase = PH_TYPE;
			run_sum = imufp_pkg::HDR_BYTE;
		end else begin
			parse_phase = PH_HUNT;
			run_sum = 8'h00;
		end
	endfunction

	// Advance the parser by one accepted byte; queue the frame result it causes.
	function automatic void parse_byte(input logic [7:0] b);
		frame_res_t r;
		logic [2:0] lookup;
		logic [3:0] mask;
		if (parse_phase == PH_TYPE) begin
			lookup = kind_of_type(b);
			if (lookup[2]) begin
				held_kind = lookup[1:0];
				run_sum = run_sum + b;
				parse_phase = PH_DATA0;
			end else begin
				// unknown type: rescan this byte as a possible header
				hunt_for_header(b);
			end
		end else if (parse_phase >= PH_DATA0 && parse_phase < PH_SUM) begin
			data_bytes[3'(parse_phase - PH_DATA0)] = b;
			run_sum = run_sum + b;
			parse_phase = parse_phase + 4'd1;
		end else if (parse_phase == PH_SUM) begin
			mask = 4'b0001 << held_kind;
			r.ok = (b == run_sum);
			seen_kinds = seen_kinds | mask;
			good_kinds = r.ok ? (good_kinds | mask) : (good_kinds & ~mask);
			r.done = (seen_kinds == 4'hF);
			r.all_ok = r.done && (good_kinds == 4'hF);
			if (r.done) begin
				seen_kinds = 4'h0;
				good_kinds = 4'h0;
			end
			r.kind = held_kind;
			r.wa = {data_bytes[1], data_bytes[0]};
			r.wb = {data_bytes[3], data_bytes[2]};
			r.wc = {data_bytes[5], data_bytes[4]};
			r.wd = {data_bytes[7], data_bytes[6]};
			frames_due.push_back(r);
			parse_phase = PH_HUNT;
			run_sum = 8'h00;
		end else begin
			hunt_for_header(b);
		end
	endfunction

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic check_frame();
		frame_res_t r;
		if (frames_due.size() == 0) begin
			$display("%0t: unexpected result: expected none, got kind %0d words %h %h %h %h",
				$time, frame_kind, word_a, word_b, word_c, word_d);
			errors++;
		end else begin
			r = frames_due.pop_front();
			check_field("frame_kind", 16'(r.kind), 16'(frame_kind));
			check_field("word_a", r.wa, word_a);
			check_field("word_b", r.wb, word_b);
			check_field("word_c", r.wc, word_c);
			check_field("word_d", r.wd, word_d);
			check_field("sum_ok", 16'(r.ok), 16'(sum_ok));
			check_field("group_done", 16'(r.done), 16'(group_done));
			check_field("group_ok", 16'(r.all_ok), 16'(group_ok));
		end
	endtask

	// Predict on accepted bytes, check accepted results, watch for a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_valid && !rx_stall)
				parse_byte(rx_byte);
			if (res_valid && !res_stall)
				check_frame();
			if ((rx_valid && !rx_stall) || (res_valid && !res_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	// Result side: random stall pattern, or one long hold-off on request.
	initial begin
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_wanted) begin
				hold_wanted = 1'b0;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			res_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Offer one byte and hold it until accepted; gaps come between bursts.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		@(negedge clk);
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
		end
		burst_left--;
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (rx_stall);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [1:0] k, input logic [15:0] wa, input logic [15:0] wb,
			input logic [15:0] wc, input logic [15:0] wd, input logic [7:0] sum_delta);
		logic [7:0] fb [10];
		logic [7:0] s;
		fb[0] = imufp_pkg::HDR_BYTE;
		fb[1] = type_of_kind(k);
		{fb[3], fb[2]} = wa;
		{fb[5], fb[4]} = wb;
		{fb[7], fb[6]} = wc;
		{fb[9], fb[8]} = wd;
		s = 8'h00;
		foreach (fb[i]) begin
			s = s + fb[i];
			send_byte(fb[i]);
		end
		send_byte(s + sum_delta);
	endtask

	// Drop valid and wait for every outstanding frame result.
	task automatic wait_results();
		@(negedge clk);
		rx_valid <= 1'b0;
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_word();
		case ($urandom_range(0, 7))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return {imufp_pkg::HDR_BYTE, 8'($urandom)};
			3:       return {8'($urandom), imufp_pkg::HDR_BYTE};
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_each_kind();
		gap_max = 2;
		stall_pct = 30;
		send_frame(imufp_pkg::KIND_ACC, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 8'h00);
		send_frame(imufp_pkg::KIND_GYRO, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 8'h00);
		send_frame(imufp_pkg::KIND_ANGLE, 16'h5555, 16'h0055, 16'h5500, 16'h1234, 8'h00);
		send_frame(imufp_pkg::KIND_QUAT, 16'hAAAA, 16'h0001, 16'hFFFE, 16'h5A5A, 8'h00);
	endtask

	task automatic test_bad_checksum();
		// bad frame later replaced by a good one of the same kind
		send_frame(imufp_pkg::KIND_ACC, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 8'h01);
		send_frame(imufp_pkg::KIND_ACC, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 8'h00);
		send_frame(imufp_pkg::KIND_ANGLE, 16'hFFFF, 16'h8000, 16'h0055, 16'h0000, 8'h80);
		send_frame(imufp_pkg::KIND_GYRO, 16'h0102, 16'h0304, 16'h0506, 16'h0708, 8'h00);
		// group closes with one kind's latest frame bad
		send_frame(imufp_pkg::KIND_QUAT, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 8'h00);
		send_frame(imufp_pkg::KIND_QUAT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'hFF);
	endtask

	task automatic test_hunting();
		logic [7:0] junk [] = '{8'h00, 8'hFF, imufp_pkg::TYPE_ACC, imufp_pkg::HDR_BYTE,
			8'h50, imufp_pkg::HDR_BYTE, 8'h54, imufp_pkg::HDR_BYTE, 8'h58,
			imufp_pkg::HDR_BYTE, 8'h5A, imufp_pkg::HDR_BYTE, 8'hFF, imufp_pkg::HDR_BYTE};
		foreach (junk[i])
			send_byte(junk[i]);
		// the header above sees another header as its type byte and restarts
		send_frame(imufp_pkg::KIND_QUAT, 16'h0055, 16'h5555, 16'h8001, 16'h7FFE, 8'h00);
	endtask

	task automatic test_hold_off();
		gap_max = 0;
		stall_pct = 0;
		hold_wanted = 1'b1;
		repeat (20)
			send_frame(2'($urandom), rand_word(), rand_word(), rand_word(), rand_word(),
				($urandom_range(0, 4) == 0) ? 8'h3C : 8'h00);
		wait_results();
	endtask

	task automatic test_random_stream();
		int start;
		int pick;
		logic [7:0] b;
		logic [2:0] lookup;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 2))
					0:       gap_max = 0;
					1:       gap_max = 3;
					default: gap_max = 10;
				endcase
				case ($urandom_range(0, 3))
					0:       stall_pct = 0;
					1:       stall_pct = 20;
					2:       stall_pct = 50;
					default: stall_pct = 80;
				endcase
			end
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				send_frame(2'($urandom), rand_word(), rand_word(), rand_word(), rand_word(),
					($urandom_range(0, 6) == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
			end else if (pick < 85) begin
				send_byte(8'($urandom));
			end else if (pick < 95) begin
				// header followed by a byte that is not a type
				do begin
					b = 8'($urandom);
					lookup = kind_of_type(b);
				end while (lookup[2]);
				send_byte(imufp_pkg::HDR_BYTE);
				send_byte(b);
			end else begin
				send_byte(imufp_pkg::HDR_BYTE);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		rx_valid = 1'b0;
		rx_byte = 8'h00;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_each_kind();
		test_bad_checksum();
		test_hunting();
		test_hold_off();
		test_random_stream();
		wait_results();

		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
